@@ hdl/mct_pkg.sv @@
// ----------------------------------------------------------------------------
// mct_pkg
// Shared types and constants for the multitouch contact tracker: controller
// states, event codes and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package mct_pkg;

    // item kinds on the input channel
    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_POINT  = 1'b1;

    // header count that means "no new data"
    localparam logic [7:0] NO_DATA_COUNT = 8'd99;

    // raw event codes in a point record
    localparam logic [1:0] EV_DOWN    = 2'd0;
    localparam logic [1:0] EV_CONTACT = 2'd2;

    // result event kinds
    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_MOVE = 2'd1;
    localparam logic [1:0] KIND_UP   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT,
        ST_RELEASE
    } mct_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;       // latch the input item
        logic exec;          // decode the latched item and update tracking state
        logic emit_point;    // load the pending down/move result into the output
        logic emit_release;  // load the next finger-up result into the output
    } mct_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic emit_pending;  // decoded item produces a down/move result
        logic go_release;    // decoded item ends a frame with ids to release
        logic gone_any;      // release set not empty
        logic gone_last;     // current release is the final one
        logic out_free;      // output register can take a result this cycle
    } mct_status_t;

endpackage

@@ hdl/mct_ctrl.sv @@
// ----------------------------------------------------------------------------
// mct_ctrl
// Controller state machine: sequences capture, decode, point result and the
// finger-up burst of the tracker datapath.
// ----------------------------------------------------------------------------
module mct_ctrl
    import mct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  mct_status_t status,
    output mct_cmd_t    cmd
);

    mct_state_t state_reg;
    mct_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                priority if (status.emit_pending)
                begin
                    state_next = ST_EMIT;
                end
                else if (status.go_release)
                begin
                    state_next = ST_RELEASE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = status.gone_any ? ST_RELEASE : ST_IDLE;
                end
            end
            ST_RELEASE:
            begin
                if (status.out_free && status.gone_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                cmd.exec = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit_point = status.out_free;
            end
            ST_RELEASE:
            begin
                cmd.emit_release = status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ hdl/mct_datapath.sv @@
// ----------------------------------------------------------------------------
// mct_datapath
// Tracker datapath: input latch, point decode, known/seen masks, per-id last
// position file, frame counters, release scan and the output register.
// ----------------------------------------------------------------------------
module mct_datapath
    import mct_pkg::*;
#(
    parameter int MAX_POINTS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mct_cmd_t    cmd,
    output mct_status_t status,
    input  logic        operation,
    input  logic [7:0]  point_count,
    input  logic [7:0]  x_high,
    input  logic [7:0]  x_low,
    input  logic [7:0]  y_high,
    input  logic [7:0]  y_low,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [3:0]  touch_id,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic        last
);

    localparam int MW  = MAX_POINTS;
    localparam int IDW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW  = $clog2(MAX_POINTS + 1);

    // latched input item
    logic       op_reg;
    logic [7:0] cnt_reg;
    logic [7:0] xh_reg;
    logic [7:0] xl_reg;
    logic [7:0] yh_reg;
    logic [7:0] yl_reg;

    // tracking state
    logic [MW-1:0] known_reg;
    logic [MW-1:0] seen_reg;
    logic [MW-1:0] gone_reg;
    logic [CW-1:0] expected_reg;
    logic [CW-1:0] taken_reg;
    logic          open_reg;
    logic [11:0]   last_x_reg [MAX_POINTS];
    logic [11:0]   last_y_reg [MAX_POINTS];

    // pending down/move result
    logic [1:0]  pend_kind_reg;
    logic [3:0]  pend_id_reg;
    logic [11:0] pend_x_reg;
    logic [11:0] pend_y_reg;
    logic        pend_last_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [3:0]  out_id_reg;
    logic [11:0] out_x_reg;
    logic [11:0] out_y_reg;
    logic        out_last_reg;

    // decode
    logic [11:0]   x_dec;
    logic [11:0]   y_dec;
    logic [3:0]    id_dec;
    logic [1:0]    ev_dec;
    logic          id_ok;
    logic [IDW-1:0] id_idx;
    logic [MW-1:0] id_bit;
    logic          is_known;
    logic          pos_diff;
    logic          act;
    logic          is_point;
    logic          is_header;
    logic          do_emit;
    logic [MW-1:0] seen_upd;
    logic [CW-1:0] taken_inc;
    logic          frame_end;
    logic          release_cond;
    logic [MW-1:0] gone_calc;
    logic          do_release;
    logic [CW-1:0] count_sat;

    // release scan
    logic [IDW-1:0] low_idx;
    logic [MW-1:0]  rel_rest;
    logic           out_free;

    always_comb
    begin
        x_dec     = {xh_reg[3:0], xl_reg};
        y_dec     = {yh_reg[3:0], yl_reg};
        id_dec    = yh_reg[7:4];
        ev_dec    = xh_reg[7:6];
        id_ok     = ({1'b0, id_dec} < 5'(MAX_POINTS));
        id_idx    = id_dec[IDW-1:0];
        id_bit    = id_ok ? (MW'(1) << id_idx) : '0;
        is_known  = |(known_reg & id_bit);
        pos_diff  = id_ok && ((x_dec != last_x_reg[id_idx]) ||
                              (y_dec != last_y_reg[id_idx]));
        act       = (ev_dec == EV_DOWN) || (ev_dec == EV_CONTACT);
        is_point  = (op_reg == OP_POINT) && open_reg;
        is_header = (op_reg == OP_HEADER);
        do_emit   = is_point && id_ok && act && (!is_known || pos_diff);
        seen_upd  = seen_reg | id_bit;
        taken_inc = taken_reg + CW'(1);
        frame_end = is_point && (taken_inc >= expected_reg);
        release_cond = (is_header && (cnt_reg == 8'd0)) || frame_end;
        gone_calc = is_header ? known_reg : (known_reg & ~seen_upd);
        do_release = release_cond && (gone_calc != '0);
        count_sat = (cnt_reg > 8'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(cnt_reg);
    end

    // lowest id still to release
    always_comb
    begin
        low_idx = '0;
        for (int i = MAX_POINTS - 1; i >= 0; i--)
        begin
            if (gone_reg[i])
            begin
                low_idx = IDW'(i);
            end
        end
        rel_rest = gone_reg & ~(MW'(1) << low_idx);
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign status.emit_pending = do_emit;
    assign status.go_release   = do_release;
    assign status.gone_any     = (gone_reg != '0);
    assign status.gone_last    = (rel_rest == '0);
    assign status.out_free     = out_free;

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            cnt_reg <= point_count;
            xh_reg  <= x_high;
            xl_reg  <= x_low;
            yh_reg  <= y_high;
            yl_reg  <= y_low;
        end
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg    <= '0;
            seen_reg     <= '0;
            gone_reg     <= '0;
            expected_reg <= '0;
            taken_reg    <= '0;
            open_reg     <= 1'b0;
        end
        else if (cmd.exec)
        begin
            gone_reg <= release_cond ? gone_calc : '0;
            if (is_header)
            begin
                seen_reg  <= '0;
                taken_reg <= '0;
                if (cnt_reg == 8'd0)
                begin
                    known_reg    <= '0;
                    open_reg     <= 1'b0;
                    expected_reg <= '0;
                end
                else if (cnt_reg != NO_DATA_COUNT)
                begin
                    expected_reg <= count_sat;
                    open_reg     <= 1'b1;
                end
                else
                begin
                    open_reg     <= 1'b0;
                    expected_reg <= '0;
                end
            end
            else if (is_point)
            begin
                if (frame_end)
                begin
                    known_reg    <= seen_upd;
                    seen_reg     <= '0;
                    open_reg     <= 1'b0;
                    expected_reg <= '0;
                    taken_reg    <= '0;
                end
                else
                begin
                    seen_reg  <= seen_upd;
                    taken_reg <= taken_inc;
                end
            end
        end
        else if (cmd.emit_release)
        begin
            gone_reg <= rel_rest;
        end
    end

    // last position file and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_emit)
        begin
            last_x_reg[id_idx] <= x_dec;
            last_y_reg[id_idx] <= y_dec;
            pend_kind_reg      <= is_known ? KIND_MOVE : KIND_DOWN;
            pend_id_reg        <= id_dec;
            pend_x_reg         <= x_dec;
            pend_y_reg         <= y_dec;
            pend_last_reg      <= !do_release;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_point || cmd.emit_release)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_point)
        begin
            out_kind_reg <= pend_kind_reg;
            out_id_reg   <= pend_id_reg;
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_last_reg <= pend_last_reg;
        end
        else if (cmd.emit_release)
        begin
            out_kind_reg <= KIND_UP;
            out_id_reg   <= 4'(low_idx);
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_last_reg <= (rel_rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign touch_id   = out_id_reg;
    assign pos_x      = out_x_reg;
    assign pos_y      = out_y_reg;
    assign last       = out_last_reg;

endmodule

@@ hdl/multitouch_contact_tracker.sv @@
// ----------------------------------------------------------------------------
// multitouch_contact_tracker
// Turns touch-controller report frames into finger-down, finger-move and
// finger-up events.
// ----------------------------------------------------------------------------
// The block takes one item per transfer: a header (operation 0) that opens a
// frame of point_count point records, or a point record (operation 1) of four
// raw bytes. Down or contact on an id that was not known when the frame opened
// gives finger-down; on a known id at a new position it gives finger-move.
// When the frame's last point arrives, or at a header with count 0, every
// known id that the frame did not mention is released with finger-up, lowest
// id first; last marks the final result of the item. A count of 99 drops the
// frame, counts above MAX_POINTS saturate, ids at or above MAX_POINTS are
// ignored, and points with no open frame are ignored. Items are handled one at
// a time by a small sequencer: each item is transferred and then decoded, a
// point with an event then loads its result, and a frame end then loads one
// finger-up per released id; every result also waits for the output register
// to be free, so stall on the result channel holds the sequencer back.
// ----------------------------------------------------------------------------
module multitouch_contact_tracker
    import mct_pkg::*;
#(
    parameter int MAX_POINTS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  point_count,
    input  logic [7:0]  x_high,
    input  logic [7:0]  x_low,
    input  logic [7:0]  y_high,
    input  logic [7:0]  y_low,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_kind,
    output logic [3:0]  touch_id,
    output logic [11:0] pos_x,
    output logic [11:0] pos_y,
    output logic        last
);

    // command and status between sequencer and datapath
    mct_cmd_t    cmd;
    mct_status_t status;

    // sequencer: idle, decode, point result, release burst
    mct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // masks, position file, frame counters and the output register
    mct_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .operation   (operation),
        .point_count (point_count),
        .x_high      (x_high),
        .x_low       (x_low),
        .y_high      (y_high),
        .y_low       (y_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .touch_id    (touch_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .last        (last)
    );

endmodule

@@ dv/contact_event_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contact_event_check
// Watches both channels of the contact tracker, tracks the contact state of
// every accepted item and compares each result transfer with the oldest
// event still due.
// ----------------------------------------------------------------------------
module contact_event_check
    import mct_pkg::*;
#(
    parameter int MAX_POINTS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  point_count,
    input  logic [7:0]  x_high,
    input  logic [7:0]  x_low,
    input  logic [7:0]  y_high,
    input  logic [7:0]  y_low,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  event_kind,
    input  logic [3:0]  touch_id,
    input  logic [11:0] pos_x,
    input  logic [11:0] pos_y,
    input  logic        last,
    output int          mismatches,
    output int          outstanding,
    output int          items_taken,
    output int          results_checked,
    output int          releases_checked
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  id;
        logic [11:0] x;
        logic [11:0] y;
        logic        last;
    } touch_event_t;

    // contact state as the block should hold it
    logic [MAX_POINTS-1:0] known_ids;
    logic [MAX_POINTS-1:0] seen_ids;
    logic [11:0]           prev_x [MAX_POINTS];
    logic [11:0]           prev_y [MAX_POINTS];
    int                    pts_total;
    int                    pts_taken;
    bit                    frame_live;

    touch_event_t batch[$];
    touch_event_t events_due[$];

    function automatic void add_event(logic [1:0] kind, logic [3:0] id,
                                      logic [11:0] px, logic [11:0] py);
        touch_event_t ev;
        ev.kind = kind;
        ev.id   = id;
        ev.x    = px;
        ev.y    = py;
        ev.last = 1'b0;
        batch.push_back(ev);
    endfunction

    // release unseen ids lowest first, seen set becomes the known set
    task automatic end_frame();
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (known_ids[i] && !seen_ids[i])
                add_event(KIND_UP, 4'(i), 12'h000, 12'h000);
        end
        known_ids  = seen_ids;
        seen_ids   = '0;
        frame_live = 1'b0;
        pts_total  = 0;
        pts_taken  = 0;
    endtask

    task automatic track_item();
        logic [11:0] px;
        logic [11:0] py;
        logic [3:0]  pid;
        logic [1:0]  pev;
        batch.delete();
        items_taken++;
        if (operation == OP_HEADER)
        begin
            frame_live = 1'b0;
            seen_ids   = '0;
            pts_total  = 0;
            pts_taken  = 0;
            if (point_count == NO_DATA_COUNT)
            begin
                // frame dropped, nothing to report
            end
            else if (point_count == 8'd0)
            begin
                if (known_ids != '0)
                    end_frame();
            end
            else
            begin
                pts_total  = (point_count > MAX_POINTS) ? MAX_POINTS : int'(point_count);
                frame_live = 1'b1;
            end
        end
        else if (frame_live)
        begin
            px  = {x_high[3:0], x_low};
            py  = {y_high[3:0], y_low};
            pid = y_high[7:4];
            pev = x_high[7:6];
            pts_taken++;
            if (pid < MAX_POINTS)
            begin
                seen_ids[pid] = 1'b1;
                if (pev == EV_DOWN || pev == EV_CONTACT)
                begin
                    if (!known_ids[pid])
                    begin
                        prev_x[pid] = px;
                        prev_y[pid] = py;
                        add_event(KIND_DOWN, pid, px, py);
                    end
                    else if (px != prev_x[pid] || py != prev_y[pid])
                    begin
                        prev_x[pid] = px;
                        prev_y[pid] = py;
                        add_event(KIND_MOVE, pid, px, py);
                    end
                end
            end
            if (pts_taken >= pts_total)
                end_frame();
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            events_due.push_back(batch[i]);
    endtask

    task automatic check_result();
        touch_event_t want;
        if (events_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected event kind %0d id %0d x %03h y %03h last %0b",
                         $time, event_kind, touch_id, pos_x, pos_y, last);
        end
        else
        begin
            want = events_due.pop_front();
            results_checked++;
            if (want.kind == KIND_UP)
                releases_checked++;
            if (event_kind !== want.kind || touch_id !== want.id || pos_x !== want.x
                || pos_y !== want.y || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: event mismatch, expected kind %0d id %0d x %03h y %03h last %0b",
                             $time, want.kind, want.id, want.x, want.y, want.last);
                    $display("%0t:                 got kind %0d id %0d x %03h y %03h last %0b",
                             $time, event_kind, touch_id, pos_x, pos_y, last);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_ids        = '0;
            seen_ids         = '0;
            pts_total        = 0;
            pts_taken        = 0;
            frame_live       = 1'b0;
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                prev_x[i] = 12'h000;
                prev_y[i] = 12'h000;
            end
            events_due.delete();
            mismatches       = 0;
            outstanding      = 0;
            items_taken      = 0;
            results_checked  = 0;
            releases_checked = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (in_valid && !in_stall)
                track_item();
            outstanding = events_due.size();
        end
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Frame-level stimulus for the multitouch contact tracker: a directed opening
// on the corner cases of the frame protocol, then random report frames with
// bursty input traffic, a stalling receiver and one long output hold-off.
// Results are checked by contact_event_check running beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import mct_pkg::*;

    localparam int MAX_POINTS     = 10;
    localparam int RANDOM_ITEMS   = 130;
    localparam int HOLDOFF_CYCLES = 300;

    // raw event codes that carry no motion
    localparam logic [1:0] EV_UP       = 2'd1;
    localparam logic [1:0] EV_RESERVED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  point_count;
    logic [7:0]  x_high;
    logic [7:0]  x_low;
    logic [7:0]  y_high;
    logic [7:0]  y_low;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  event_kind;
    logic [3:0]  touch_id;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic        last;

    int mismatches;
    int outstanding;
    int items_taken;
    int results_checked;
    int releases_checked;

    // asks the receiver for its one long hold-off
    logic holdoff_req;

    // sender-side view of the frame, only used to shape stimulus:
    // a position that was never written must never be compared, so an id
    // gets a down or contact before any up or reserved event is sent for it
    bit          frame_on;
    int          points_left;
    bit          pos_written [16];
    bit [11:0]   sent_x [16];
    bit [11:0]   sent_y [16];
    int          burst_left;
    int          counted_items;

    multitouch_contact_tracker #(
        .MAX_POINTS (MAX_POINTS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .point_count (point_count),
        .x_high      (x_high),
        .x_low       (x_low),
        .y_high      (y_high),
        .y_low       (y_low),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .touch_id    (touch_id),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .last        (last)
    );

    contact_event_check #(
        .MAX_POINTS (MAX_POINTS)
    ) event_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .operation        (operation),
        .point_count      (point_count),
        .x_high           (x_high),
        .x_low            (x_low),
        .y_high           (y_high),
        .y_low            (y_low),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_kind       (event_kind),
        .touch_id         (touch_id),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .last             (last),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .items_taken      (items_taken),
        .results_checked  (results_checked),
        .releases_checked (releases_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one input transfer, then the burst bookkeeping: when a burst runs out
    // valid drops for a random gap, and the next burst length is drawn
    task automatic xfer(input logic op, input logic [7:0] cnt, input logic [7:0] xh,
                        input logic [7:0] xl, input logic [7:0] yh, input logic [7:0] yl);
        int gap;
        operation   <= op;
        point_count <= cnt;
        x_high      <= xh;
        x_low       <= xl;
        y_high      <= yh;
        y_low       <= yl;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            // now and then a long burst with no idling at all
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 10);
        end
    endtask

    task automatic send_header(input logic [7:0] cnt);
        if (cnt == NO_DATA_COUNT || cnt == 8'd0)
            frame_on = 1'b0;
        else
        begin
            frame_on    = 1'b1;
            points_left = (cnt > MAX_POINTS) ? MAX_POINTS : int'(cnt);
        end
        counted_items++;
        // the point fields are don't-care in a header, so they carry noise
        xfer(OP_HEADER, cnt, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_point(input logic [1:0] ev, input logic [3:0] id,
                              input logic [11:0] px, input logic [11:0] py);
        logic [1:0] code;
        code = ev;
        if (frame_on)
        begin
            // keep clear of a never-written position
            if (id < MAX_POINTS && !pos_written[id] && (code == EV_UP || code == EV_RESERVED))
                code = $urandom_range(0, 1) ? EV_DOWN : EV_CONTACT;
            if (id < MAX_POINTS && (code == EV_DOWN || code == EV_CONTACT))
                pos_written[id] = 1'b1;
            points_left--;
            if (points_left == 0)
                frame_on = 1'b0;
            counted_items++;
        end
        sent_x[id] = px;
        sent_y[id] = py;
        // x_high bits 5:4 are unused by the block and get noise
        xfer(OP_POINT, 8'($urandom), {code, 2'($urandom), px[11:8]}, px[7:0],
             {id, py[11:8]}, py[7:0]);
    endtask

    // a report frame with random content; about one in ten is cut short so
    // the following header abandons it
    task automatic random_frame();
        int          count;
        int          n;
        int          roll;
        logic [3:0]  id;
        logic [1:0]  ev;
        logic [11:0] px;
        logic [11:0] py;
        if ($urandom_range(0, 9) == 0)
            count = $urandom_range(MAX_POINTS + 1, 255);
        else
            count = $urandom_range(1, MAX_POINTS);
        if (count == NO_DATA_COUNT)
            count = 255;
        n = (count > MAX_POINTS) ? MAX_POINTS : count;
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(0, n - 1);
        send_header(8'(count));
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                id = 4'($urandom_range(MAX_POINTS, 15));
            else
                id = 4'($urandom_range(0, MAX_POINTS - 1));
            roll = $urandom_range(0, 99);
            if (roll < 45)
                ev = EV_CONTACT;
            else if (roll < 70)
                ev = EV_DOWN;
            else if (roll < 85)
                ev = EV_UP;
            else
                ev = EV_RESERVED;
            // half the time the id reuses its last sent position
            if ($urandom_range(0, 1) == 1)
            begin
                px = sent_x[id];
                py = sent_y[id];
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                px = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                py = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
            end
            else
            begin
                px = 12'($urandom);
                py = 12'($urandom);
            end
            send_point(ev, id, px, py);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int goal;
        int roll;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        operation   <= OP_HEADER;
        point_count <= 8'd0;
        x_high      <= 8'd0;
        x_low       <= 8'd0;
        y_high      <= 8'd0;
        y_low       <= 8'd0;
        holdoff_req <= 1'b0;
        burst_left    = 1;
        counted_items = 0;
        frame_on      = 1'b0;
        points_left   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty frame with nothing known, no-data header, stray point
        send_header(8'd0);
        send_header(NO_DATA_COUNT);
        send_point(EV_CONTACT, 4'd2, 12'h234, 12'h567);
        // two downs at the coordinate extremes, one id out of range
        send_header(8'd3);
        send_point(EV_DOWN, 4'd0, 12'hFFF, 12'hFFF);
        send_point(EV_CONTACT, 4'd9, 12'h000, 12'h000);
        send_point(EV_DOWN, 4'd15, 12'hABC, 12'h123);
        // same position gives nothing, new position gives a move
        send_header(8'd2);
        send_point(EV_CONTACT, 4'd0, 12'hFFF, 12'hFFF);
        send_point(EV_CONTACT, 4'd9, 12'h800, 12'h001);
        // oversized count saturates, then a header abandons the frame
        send_header(8'd200);
        send_point(EV_DOWN, 4'd4, 12'h555, 12'hAAA);
        send_header(8'd1);
        // an up event keeps id 0 known, id 9 is released
        send_point(EV_UP, 4'd0, 12'h000, 12'h000);
        // empty frame with a known id releases it
        send_header(8'd0);
        // repeated new id in one frame gives two downs
        send_header(8'd2);
        send_point(EV_DOWN, 4'd5, 12'h100, 12'h200);
        send_point(EV_DOWN, 4'd5, 12'h101, 12'h200);
        // reserved event keeps id 5 known without any event
        send_header(8'd1);
        send_point(EV_RESERVED, 4'd5, 12'h3C3, 12'hC3C);
        // a move inside a frame that no-data then drops, then a stray point
        send_header(8'd10);
        send_point(EV_CONTACT, 4'd5, 12'h7FF, 12'h800);
        send_header(NO_DATA_COUNT);
        send_point(EV_DOWN, 4'd6, 12'h0F0, 12'hF0F);

        goal = counted_items + RANDOM_ITEMS;
        while (counted_items < goal)
        begin
            // long output hold-off partway through, while items keep coming
            if (!holdoff_req && counted_items >= goal - 100)
                holdoff_req <= 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 72)
                random_frame();
            else if (roll < 80)
                send_header(8'd0);
            else if (roll < 86)
                send_header(NO_DATA_COUNT);
            else if (roll < 94)
                send_point(2'($urandom), 4'($urandom), 12'($urandom), 12'($urandom));
            else
                send_header(8'($urandom));
        end
        in_valid <= 1'b0;

        // drain: every event due has to come out, then a quiet tail
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(posedge clk);

        $display("run covered %0d input transfers and %0d checked events, %0d of them releases",
                 items_taken, results_checked, releases_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // receiver: stall pattern in spans of its own, from no stall at all to
    // mostly stalled, plus the single long hold-off on request
    initial
    begin
        int  mode;
        int  span;
        bit  holdoff_done;
        holdoff_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 40);
            repeat (span)
            begin
                @(posedge clk);
                if (holdoff_req && !holdoff_done)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLDOFF_CYCLES - 1) @(posedge clk);
                    holdoff_done = 1'b1;
                end
                else
                begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 1) == 0);
                        default: out_stall <= ($urandom_range(0, 3) != 0);
                    endcase
                end
            end
        end
    end

    // limit on the whole run
    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
